/* design/maze_flood_fill_solver_assert.svh */
// ----------------------------------------------------------------------------
// Maze flood-fill solver assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MAZE_FLOOD_FILL_SOLVER_ASSERT_SVH
`define MAZE_FLOOD_FILL_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/mfs_pkg.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver package
// Shared types, codes and helpers for the controller and the datapath.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int MFS_GRID_SIDE = 16;
    // Internal coordinates carry one extra bit so that x+1 and y+1 fit.
    localparam int COORD_W = 5;
    localparam int FIELD_W = 4;
    localparam int DIST_W  = 8;
    localparam logic [DIST_W-1:0] DIST_UNREACHED = 8'hFF;

    localparam logic [1:0] ACT_WALL  = 2'd0;
    localparam logic [1:0] ACT_FLOOD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_FRONT = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] cell_x;
        logic [FIELD_W-1:0] cell_y;
        logic [1:0]         heading;
        logic               wall_left;
        logic               wall_front;
        logic               wall_right;
        logic               goal_select;
    } t_item;

    typedef struct packed {
        logic [1:0]        move_dir;
        logic              move_found;
        logic [DIST_W-1:0] cell_dist;
        logic              at_goal;
    } t_result;

    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       wall_wr;
        logic [1:0] wall_side;
        logic       dist_clear;
        logic       seed;
        logic       pop_rd;
        logic       rd_queue;
        logic       rd_cell;
        logic       base_ld;
        logic       nb_first;
        logic       nb_next;
        logic       relax;
        logic       res_oor;
        logic       res_hit;
        logic       res_miss;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic wclr_last;
        logic in_range;
        logic is_flood;
        logic seed_last;
        logic q_empty;
        logic nb_last;
        logic nb_hit;
        logic out_free;
    } t_stat;

    // Query tries neighbors north, east, west, south.
    function automatic logic [1:0] query_dir(input logic [1:0] step);
        logic [1:0] d;
        unique case (step)
            2'd0:    d = DIR_N;
            2'd1:    d = DIR_E;
            2'd2:    d = DIR_W;
            default: d = DIR_S;
        endcase
        return d;
    endfunction

endpackage

/* design/mfs_if.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] heading;
    logic       wall_left;
    logic       wall_front;
    logic       wall_right;
    logic       goal_select;

    modport source (output valid, action, cell_x, cell_y, heading, wall_left,
                    wall_front, wall_right, goal_select, input ready);
    modport sink   (input valid, action, cell_x, cell_y, heading, wall_left,
                    wall_front, wall_right, goal_select, output ready);
endinterface

interface mfs_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] move_dir;
    logic       move_found;
    logic [7:0] cell_dist;
    logic       at_goal;

    modport source (output valid, move_dir, move_found, cell_dist, at_goal,
                    input ready);
    modport sink   (input valid, move_dir, move_found, cell_dist, at_goal,
                    output ready);
endinterface

/* design/mfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/mfs_datapath.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver datapath
// Wall, distance and queue memories, cell registers and the result register.
// ----------------------------------------------------------------------------
`include "maze_flood_fill_solver_assert.svh"

module mfs_datapath import mfs_pkg::*; #(
    parameter int GRID_SIDE = MFS_GRID_SIDE
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_result o_result
);
    localparam int NCELL  = GRID_SIDE * GRID_SIDE;
    localparam int WSIDE  = GRID_SIDE + 1;
    localparam int WDEPTH = 2 * WSIDE * WSIDE;
    localparam int CAW    = $clog2(NCELL);
    localparam int WAW    = $clog2(WDEPTH);
    localparam int QCW    = $clog2(NCELL + 1);
    localparam logic [COORD_W-1:0] SIDE_C = COORD_W'(GRID_SIDE);
    localparam logic [COORD_W-1:0] HI_C   = COORD_W'(GRID_SIDE / 2);
    localparam logic [COORD_W-1:0] LO_C   = COORD_W'(GRID_SIDE / 2 - 1);

    function automatic logic [CAW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
        return CAW'(int'(x) * GRID_SIDE + int'(y));
    endfunction

    // West wall of (x,y) is bit 0 of its slot, south wall is bit 1.
    function automatic logic [WAW-1:0] wall_addr(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y,
                                                 input logic [1:0] dir);
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
        logic               k;
        wx = x;
        wy = y;
        unique case (dir)
            DIR_N: begin
                wy = y + 1'b1;
                k  = 1'b1;
            end
            DIR_E: begin
                wx = x + 1'b1;
                k  = 1'b0;
            end
            DIR_S:   k = 1'b1;
            default: k = 1'b0;
        endcase
        return WAW'((int'(wx) * WSIDE + int'(wy)) * 2 + int'(k));
    endfunction

    logic [COORD_W-1:0] r_cx, r_cy;
    logic [1:0]         r_head_dir;
    logic               r_wl, r_wf, r_wr, r_g, r_flood;
    logic [DIST_W-1:0]  r_base;
    logic [1:0]         r_nb, r_sidx;
    logic [WAW-1:0]     r_wcnt;
    logic [QCW-1:0]     r_head, r_tail;
    logic [NCELL-1:0]   r_dvld;
    logic               r_dvq;
    t_result            r_res;
    logic               r_ovalid;
    t_result            r_out;

    logic [1:0]         nb_dir;
    logic [COORD_W-1:0] nx, ny, sx, sy;
    logic               inb;
    logic [1:0]         wdir;
    logic               wval;
    logic               w_we, w_wdata, w_q;
    logic [WAW-1:0]     w_waddr, w_raddr;
    logic               d_we;
    logic [CAW-1:0]     d_waddr, d_raddr;
    logic [DIST_W-1:0]  d_wdata, d_q, dq;
    logic               q_we;
    logic [7:0]         q_wdata, q_q;
    logic [COORD_W-1:0] qx, qy;
    logic [8:0]         nd;
    logic               open_nb, tail_ok, relax_go, hit;

    assign nb_dir = r_flood ? r_nb : query_dir(r_nb);

    always_comb begin
        nx  = r_cx;
        ny  = r_cy;
        inb = 1'b0;
        unique case (nb_dir)
            DIR_N: begin
                ny  = r_cy + 1'b1;
                inb = (r_cy + 1'b1) < SIDE_C;
            end
            DIR_E: begin
                nx  = r_cx + 1'b1;
                inb = (r_cx + 1'b1) < SIDE_C;
            end
            DIR_S: begin
                ny  = r_cy - 1'b1;
                inb = r_cy != '0;
            end
            default: begin
                nx  = r_cx - 1'b1;
                inb = r_cx != '0;
            end
        endcase
    end

    // Left, front and right map onto compass sides relative to the heading.
    always_comb begin
        unique case (i_cmd.wall_side)
            SIDE_LEFT: begin
                wdir = r_head_dir - 1'b1;
                wval = r_wl;
            end
            SIDE_FRONT: begin
                wdir = r_head_dir;
                wval = r_wf;
            end
            default: begin
                wdir = r_head_dir + 1'b1;
                wval = r_wr;
            end
        endcase
    end

    always_comb begin
        sx = '0;
        sy = '0;
        if (!r_g) begin
            unique case (r_sidx)
                2'd0: begin
                    sx = HI_C;
                    sy = HI_C;
                end
                2'd1: begin
                    sx = LO_C;
                    sy = HI_C;
                end
                2'd2: begin
                    sx = HI_C;
                    sy = LO_C;
                end
                default: begin
                    sx = LO_C;
                    sy = LO_C;
                end
            endcase
        end
    end

    assign w_we    = i_cmd.clr_step | i_cmd.wall_wr;
    assign w_waddr = i_cmd.clr_step ? r_wcnt : wall_addr(r_cx, r_cy, wdir);
    assign w_wdata = i_cmd.clr_step ? 1'b0 : wval;
    assign w_raddr = wall_addr(r_cx, r_cy, nb_dir);

    mfs_ram #(.WIDTH(1), .DEPTH(WDEPTH)) u_wall_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    assign dq       = r_dvq ? d_q : DIST_UNREACHED;
    assign nd       = {1'b0, r_base} + 9'd1;
    assign open_nb  = inb && !w_q;
    assign tail_ok  = r_tail < QCW'(NCELL);
    assign relax_go = i_cmd.relax && open_nb && (nd < 9'(DIST_UNREACHED))
                      && ({1'b0, dq} > nd) && tail_ok;
    assign hit      = open_nb && (dq < r_base);

    assign qx = {1'b0, q_q[7:4]};
    assign qy = {1'b0, q_q[3:0]};

    assign d_we    = (i_cmd.seed && tail_ok) || relax_go;
    assign d_waddr = i_cmd.seed ? cell_addr(sx, sy) : cell_addr(nx, ny);
    assign d_wdata = i_cmd.seed ? '0 : nd[DIST_W-1:0];

    always_comb begin
        priority if (i_cmd.rd_queue) begin
            d_raddr = cell_addr(qx, qy);
        end else if (i_cmd.rd_cell) begin
            d_raddr = cell_addr(r_cx, r_cy);
        end else begin
            d_raddr = cell_addr(nx, ny);
        end
    end

    mfs_ram #(.WIDTH(DIST_W), .DEPTH(NCELL)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_q)
    );

    assign q_we    = d_we;
    assign q_wdata = i_cmd.seed ? {sx[FIELD_W-1:0], sy[FIELD_W-1:0]}
                                : {nx[FIELD_W-1:0], ny[FIELD_W-1:0]};

    mfs_ram #(.WIDTH(8), .DEPTH(NCELL)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_tail[CAW-1:0]),
        .i_wdata (q_wdata),
        .i_raddr (r_head[CAW-1:0]),
        .o_rdata (q_q)
    );

    always_ff @(posedge i_clk) begin
        r_dvq <= r_dvld[d_raddr];
        if (i_cmd.load_item) begin
            r_cx       <= {1'b0, i_item.cell_x};
            r_cy       <= {1'b0, i_item.cell_y};
            r_head_dir <= i_item.heading;
            r_wl       <= i_item.wall_left;
            r_wf       <= i_item.wall_front;
            r_wr       <= i_item.wall_right;
            r_g        <= i_item.goal_select;
            r_flood    <= i_item.action == ACT_FLOOD;
            // An out-of-range query reports an unreached distance.
            r_res.move_dir   <= DIR_N;
            r_res.move_found <= 1'b0;
            r_res.cell_dist  <= i_cmd.res_oor ? DIST_UNREACHED : '0;
            r_res.at_goal    <= 1'b0;
        end
        if (i_cmd.rd_queue) begin
            r_cx <= qx;
            r_cy <= qy;
        end
        if (i_cmd.base_ld) begin
            r_base <= dq;
        end
        if (i_cmd.nb_first) begin
            r_nb <= '0;
        end else if (i_cmd.nb_next) begin
            r_nb <= r_nb + 1'b1;
        end
        if (i_cmd.dist_clear) begin
            r_sidx <= '0;
        end else if (i_cmd.seed) begin
            r_sidx <= r_sidx + 1'b1;
        end
        if (i_cmd.res_hit) begin
            r_res.move_dir   <= nb_dir;
            r_res.move_found <= 1'b1;
            r_res.cell_dist  <= r_base;
            r_res.at_goal    <= dq == '0;
        end
        if (i_cmd.res_miss) begin
            r_res.move_dir   <= DIR_N;
            r_res.move_found <= 1'b0;
            r_res.cell_dist  <= r_base;
            r_res.at_goal    <= r_base == '0;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_dvld   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (i_cmd.dist_clear) begin
                r_head <= '0;
                r_tail <= '0;
                r_dvld <= '0;
            end else begin
                if (i_cmd.pop_rd) begin
                    r_head <= r_head + 1'b1;
                end
                if (q_we) begin
                    r_tail <= r_tail + 1'b1;
                end
                if (d_we) begin
                    r_dvld[d_waddr] <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.wclr_last = r_wcnt == WAW'(WDEPTH - 1);
    assign o_stat.in_range  = ({1'b0, i_item.cell_x} < SIDE_C)
                              && ({1'b0, i_item.cell_y} < SIDE_C);
    assign o_stat.is_flood  = r_flood;
    assign o_stat.seed_last = r_g || (r_sidx == 2'd3);
    assign o_stat.q_empty   = r_head == r_tail;
    assign o_stat.nb_last   = r_nb == 2'd3;
    assign o_stat.nb_hit    = hit;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_result    = r_out;

    `MFS_ASSERT_SAME(a_pop_nonempty, i_cmd.pop_rd, r_head != r_tail, "pop from empty queue")
    `MFS_ASSERT_SAME(a_push_marks, q_we, d_we && tail_ok, "queue push without distance write")
    `MFS_ASSERT_NEXT(a_head_step, i_cmd.pop_rd && !i_cmd.dist_clear,
        r_head == $past(r_head) + 1'b1, "queue head did not advance")
    `MFS_ASSERT_SAME(a_emit_free, i_cmd.emit, !r_ovalid || i_out_ready,
        "result overwrites an untaken result")
endmodule

/* design/mfs_controller.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver controller
// Sequences wall clearing, wall writes, the flood and the query.
// ----------------------------------------------------------------------------
module mfs_controller import mfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_action,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);
    typedef enum logic [14:0] {
        S_CLR   = 15'b000000000000001,
        S_IDLE  = 15'b000000000000010,
        S_WALL0 = 15'b000000000000100,
        S_WALL1 = 15'b000000000001000,
        S_WALL2 = 15'b000000000010000,
        S_FCLR  = 15'b000000000100000,
        S_SEED  = 15'b000000001000000,
        S_POP   = 15'b000000010000000,
        S_PLD   = 15'b000000100000000,
        S_BASE  = 15'b000001000000000,
        S_NRD   = 15'b000010000000000,
        S_NCHK  = 15'b000100000000000,
        S_QRD   = 15'b001000000000000,
        S_QBASE = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.wclr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_action)
                        ACT_WALL:  n_state = i_stat.in_range ? S_WALL0 : S_EMIT;
                        ACT_FLOOD: n_state = S_FCLR;
                        ACT_QUERY: begin
                            if (i_stat.in_range) begin
                                n_state = S_QRD;
                            end else begin
                                o_cmd.res_oor = 1'b1;
                                n_state       = S_EMIT;
                            end
                        end
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_WALL0: begin
                o_cmd.wall_wr   = 1'b1;
                o_cmd.wall_side = SIDE_LEFT;
                n_state         = S_WALL1;
            end
            S_WALL1: begin
                o_cmd.wall_wr   = 1'b1;
                o_cmd.wall_side = SIDE_FRONT;
                n_state         = S_WALL2;
            end
            S_WALL2: begin
                o_cmd.wall_wr   = 1'b1;
                o_cmd.wall_side = SIDE_RIGHT;
                n_state         = S_EMIT;
            end
            S_FCLR: begin
                o_cmd.dist_clear = 1'b1;
                n_state          = S_SEED;
            end
            S_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_stat.seed_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_stat.q_empty) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                    n_state      = S_PLD;
                end
            end
            S_PLD: begin
                o_cmd.rd_queue = 1'b1;
                n_state        = S_BASE;
            end
            S_BASE, S_QBASE: begin
                o_cmd.base_ld  = 1'b1;
                o_cmd.nb_first = 1'b1;
                n_state        = S_NRD;
            end
            S_NRD: begin
                n_state = S_NCHK;
            end
            S_NCHK: begin
                if (i_stat.is_flood) begin
                    o_cmd.relax = 1'b1;
                    if (i_stat.nb_last) begin
                        n_state = S_POP;
                    end else begin
                        o_cmd.nb_next = 1'b1;
                        n_state       = S_NRD;
                    end
                end else begin
                    priority if (i_stat.nb_hit) begin
                        o_cmd.res_hit = 1'b1;
                        n_state       = S_EMIT;
                    end else if (i_stat.nb_last) begin
                        o_cmd.res_miss = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.nb_next = 1'b1;
                        n_state       = S_NRD;
                    end
                end
            end
            S_QRD: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_QBASE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* design/maze_flood_fill_solver.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver
// Wall map, breadth-first distance flood and next-move query over a grid.
// ----------------------------------------------------------------------------
// After reset the block clears its wall memory, one wall bit a cycle,
// before it takes its first item. A query checks the neighbors of its cell
// one at a time until it finds one with a lower distance. A flood seeds the
// start cell or the four center cells; then each reached cell is dequeued
// and its four neighbors are checked one at a time through the registered
// read ports of the wall and distance memories. One item is in work at a
// time; the next item is taken while the previous result still waits in the
// output register.
module maze_flood_fill_solver import mfs_pkg::*; #(
    parameter int GRID_SIDE = MFS_GRID_SIDE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mfs_in_if.sink     i_item,
    mfs_out_if.source  o_result
);
    t_item   item;
    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    out_valid;
    logic    ready;

    assign item.action      = i_item.action;
    assign item.cell_x      = i_item.cell_x;
    assign item.cell_y      = i_item.cell_y;
    assign item.heading     = i_item.heading;
    assign item.wall_left   = i_item.wall_left;
    assign item.wall_front  = i_item.wall_front;
    assign item.wall_right  = i_item.wall_right;
    assign item.goal_select = i_item.goal_select;

    mfs_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_ready  (ready),
        .o_cmd    (cmd)
    );

    mfs_datapath #(.GRID_SIDE(GRID_SIDE)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_result.ready),
        .o_out_valid (out_valid),
        .o_result    (res)
    );

    assign i_item.ready        = ready;
    assign o_result.valid      = out_valid;
    assign o_result.move_dir   = res.move_dir;
    assign o_result.move_found = res.move_found;
    assign o_result.cell_dist  = res.cell_dist;
    assign o_result.at_goal    = res.at_goal;
endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Maze flood-fill solver testbench
// Drives wall writes, floods and next-move queries through the item channel.
// A local maze model predicts each result, and every result transfer is
// checked field by field against the oldest prediction. Both channel sides
// idle at random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import mfs_pkg::*;

    localparam int SIDE       = MFS_GRID_SIDE;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 300;

    logic i_clk;
    logic i_rst_n;

    mfs_in_if  item_ch ();
    mfs_out_if result_ch ();

    maze_flood_fill_solver i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Model of the maze: [x][y][0] is the west wall, [x][y][1] the south wall.
    bit         maze_wall [0:SIDE][0:SIDE][0:1];
    logic [7:0] maze_dist [0:SIDE-1][0:SIDE-1];

    t_result expected_moves[$];
    int      mismatches;
    int      idle_cycles;
    bit      no_gaps;
    bit      hold_request;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void put_wall(int x, int y, int k, bit v);
        maze_wall[x][y][k] = v;
    endfunction

    function automatic void write_walls(t_item it);
        int x;
        int y;
        x = it.cell_x;
        y = it.cell_y;
        case (it.heading)
            DIR_N: begin
                put_wall(x, y, 0, it.wall_left);
                put_wall(x, y + 1, 1, it.wall_front);
                put_wall(x + 1, y, 0, it.wall_right);
            end
            DIR_E: begin
                put_wall(x, y + 1, 1, it.wall_left);
                put_wall(x + 1, y, 0, it.wall_front);
                put_wall(x, y, 1, it.wall_right);
            end
            DIR_S: begin
                put_wall(x + 1, y, 0, it.wall_left);
                put_wall(x, y, 1, it.wall_front);
                put_wall(x, y, 0, it.wall_right);
            end
            default: begin
                put_wall(x, y, 1, it.wall_left);
                put_wall(x, y, 0, it.wall_front);
                put_wall(x, y + 1, 1, it.wall_right);
            end
        endcase
    endfunction

    function automatic void flood_distances(bit from_start);
        int frontier[$];
        int c;
        int x;
        int y;
        int nd;
        int nx[4];
        int ny[4];
        bit open[4];
        int hi;
        int lo;
        int seeds[$];
        foreach (maze_dist[i, j]) maze_dist[i][j] = DIST_UNREACHED;
        hi = SIDE / 2;
        lo = SIDE / 2 - 1;
        if (from_start) seeds = '{0};
        else seeds = '{hi * SIDE + hi, lo * SIDE + hi, hi * SIDE + lo, lo * SIDE + lo};
        foreach (seeds[i]) begin
            if (maze_dist[seeds[i] / SIDE][seeds[i] % SIDE] != 0) begin
                maze_dist[seeds[i] / SIDE][seeds[i] % SIDE] = 0;
                frontier.push_back(seeds[i]);
            end
        end
        while (frontier.size() > 0) begin
            c  = frontier.pop_front();
            x  = c / SIDE;
            y  = c % SIDE;
            nd = maze_dist[x][y] + 1;
            nx = '{x, x + 1, x, x - 1};
            ny = '{y + 1, y, y - 1, y};
            open[0] = (y + 1 < SIDE) && !maze_wall[x][y + 1][1];
            open[1] = (x + 1 < SIDE) && !maze_wall[x + 1][y][0];
            open[2] = (y >= 1) && !maze_wall[x][y][1];
            open[3] = (x >= 1) && !maze_wall[x][y][0];
            for (int k = 0; k < 4; k++) begin
                if (open[k] && nd < DIST_UNREACHED && maze_dist[nx[k]][ny[k]] > nd) begin
                    maze_dist[nx[k]][ny[k]] = nd;
                    frontier.push_back(nx[k] * SIDE + ny[k]);
                end
            end
        end
    endfunction

    function automatic t_result next_move(int x, int y);
        t_result r;
        int d;
        int nd;
        r = '0;
        if (x >= SIDE || y >= SIDE) begin
            r.cell_dist = DIST_UNREACHED;
            return r;
        end
        d  = maze_dist[x][y];
        nd = d;
        r.move_found = 1'b1;
        if (y + 1 < SIDE && !maze_wall[x][y + 1][1] && maze_dist[x][y + 1] < d) begin
            r.move_dir = DIR_N;
            nd = maze_dist[x][y + 1];
        end else if (x + 1 < SIDE && !maze_wall[x + 1][y][0] && maze_dist[x + 1][y] < d) begin
            r.move_dir = DIR_E;
            nd = maze_dist[x + 1][y];
        end else if (x >= 1 && !maze_wall[x][y][0] && maze_dist[x - 1][y] < d) begin
            r.move_dir = DIR_W;
            nd = maze_dist[x - 1][y];
        end else if (y >= 1 && !maze_wall[x][y][1] && maze_dist[x][y - 1] < d) begin
            r.move_dir = DIR_S;
            nd = maze_dist[x][y - 1];
        end else begin
            r.move_found = 1'b0;
        end
        r.cell_dist = d[7:0];
        r.at_goal   = (nd == 0);
        return r;
    endfunction

    function automatic t_result solve_step(t_item it);
        t_result r;
        r = '0;
        case (it.action)
            ACT_WALL:  if (it.cell_x < SIDE && it.cell_y < SIDE) write_walls(it);
            ACT_FLOOD: flood_distances(it.goal_select);
            ACT_QUERY: r = next_move(it.cell_x, it.cell_y);
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_item make_item(logic [1:0] action);
        t_item it;
        it = t_item'($urandom);
        it.action = action;
        return it;
    endfunction

    function automatic int draw_gap();
        if (no_gaps) return 0;
        return $urandom_range(0, 9);
    endfunction

    // The valid stays high across back-to-back transfers.
    task automatic send_item(t_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.action      <= it.action;
        item_ch.cell_x      <= it.cell_x;
        item_ch.cell_y      <= it.cell_y;
        item_ch.heading     <= it.heading;
        item_ch.wall_left   <= it.wall_left;
        item_ch.wall_front  <= it.wall_front;
        item_ch.wall_right  <= it.wall_right;
        item_ch.goal_select <= it.goal_select;
        do @(posedge i_clk); while (!(item_ch.valid && item_ch.ready));
        expected_moves.push_back(solve_step(it));
    endtask

    task automatic send_cell(logic [1:0] action, int x, int y, logic [1:0] heading,
                             bit l, bit f, bit r, bit g);
        t_item it;
        it             = '0;
        it.action      = action;
        it.cell_x      = x[3:0];
        it.cell_y      = y[3:0];
        it.heading     = heading;
        it.wall_left   = l;
        it.wall_front  = f;
        it.wall_right  = r;
        it.goal_select = g;
        send_item(it);
    endtask

    // The last item must not be offered again while the results drain.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (expected_moves.size() > 0) @(posedge i_clk);
    endtask

    task automatic report_field(string field, int exp_v, int act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v,
                     act_v);
        end
    endtask

    initial begin
        t_result want;
        int stall;
        result_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_gap();
            if (hold_request) begin
                stall = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
            if (expected_moves.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with nothing expected", $time);
            end else begin
                want = expected_moves.pop_front();
                report_field("move_dir", want.move_dir, result_ch.move_dir);
                report_field("move_found", want.move_found, result_ch.move_found);
                report_field("cell_dist", want.cell_dist, result_ch.cell_dist);
                report_field("at_goal", want.at_goal, result_ch.at_goal);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("** maze_flood_fill_solver: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        // Query before any flood: every cell is unreached.
        send_cell(ACT_QUERY, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_WALL, 0, 0, DIR_N, 1, 1, 1, 0);
        send_cell(ACT_WALL, 15, 15, DIR_E, 1, 1, 1, 1);
        send_cell(ACT_WALL, 15, 0, DIR_S, 1, 0, 1, 0);
        send_cell(ACT_WALL, 0, 15, DIR_W, 0, 1, 0, 1);
        send_cell(ACT_WALL, 7, 8, DIR_N, 0, 1, 1, 0);
        send_cell(ACT_NONE, 15, 15, DIR_W, 1, 1, 1, 1);
        send_cell(ACT_FLOOD, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 8, 8, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 7, 9, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 15, 15, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 15, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_FLOOD, 0, 0, DIR_N, 0, 0, 0, 1);
        send_cell(ACT_QUERY, 0, 1, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 1, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 15, 15, DIR_N, 0, 0, 0, 0);
        // Clear the walls again so the corner is reachable.
        send_cell(ACT_WALL, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_WALL, 7, 8, DIR_N, 0, 0, 0, 0);
    endtask

    // A snake through every cell: the far end lies 255 steps from the start
    // and must stay unreached.
    task automatic test_deep_path();
        bit east;
        bit west;
        for (int x = 0; x < SIDE; x++) begin
            for (int y = 0; y < SIDE; y++) begin
                east = (x == SIDE - 1) ||
                       !(((x % 2) == 0 && y == SIDE - 1) || ((x % 2) == 1 && y == 0));
                west = (x == 0) ||
                       !((((x - 1) % 2) == 0 && y == SIDE - 1) || (((x - 1) % 2) == 1 && y == 0));
                send_cell(ACT_WALL, x, y, DIR_N, west, 0, east, 0);
            end
        end
        send_cell(ACT_FLOOD, 0, 0, DIR_N, 0, 0, 0, 1);
        send_cell(ACT_QUERY, 15, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 15, 1, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 14, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 0, 1, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_FLOOD, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 0, 0, DIR_N, 0, 0, 0, 0);
        send_cell(ACT_QUERY, 8, 7, DIR_N, 0, 0, 0, 0);
    endtask

    task automatic send_random(int count);
        int pick;
        logic [1:0] action;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)      action = ACT_WALL;
            else if (pick < 92) action = ACT_QUERY;
            else if (pick < 97) action = ACT_FLOOD;
            else                action = ACT_NONE;
            send_item(make_item(action));
        end
    endtask

    task automatic test_random_maze();
        send_random(200);
    endtask

    task automatic test_output_stall();
        no_gaps = 1'b1;
        hold_request = 1'b1;
        send_random(25);
        no_gaps = 1'b0;
    endtask

    task automatic test_sender_pause();
        send_random(10);
        wait_drained();
        send_random(10);
    endtask

    task automatic test_back_to_back();
        no_gaps = 1'b1;
        send_random(40);
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_NONE;
        item_ch.cell_x = '0;
        item_ch.cell_y = '0;
        item_ch.heading = DIR_N;
        item_ch.wall_left = 1'b0;
        item_ch.wall_front = 1'b0;
        item_ch.wall_right = 1'b0;
        item_ch.goal_select = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        hold_request = 1'b0;
        foreach (maze_wall[i, j, k]) maze_wall[i][j][k] = 1'b0;
        foreach (maze_dist[i, j]) maze_dist[i][j] = DIST_UNREACHED;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_deep_path();
        test_random_maze();
        test_output_stall();
        test_sender_pause();
        test_back_to_back();

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_moves.size() == 0)
            $display("** maze_flood_fill_solver: PASSED **");
        else
            $display("** maze_flood_fill_solver: FAILED **");
        $finish;
    end
endmodule
